// ----- src/bfa_pkg.sv -----
// types and constants shared by the best-fit block allocator
package bfa_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
  localparam logic [2:0] ST_DOUBLE    = 3'd4;

  localparam logic [1:0] REG_HEADER    = 2'd0;
  localparam logic [1:0] REG_MAX_BLOCK = 2'd1;
  localparam logic [1:0] REG_MIN_SPLIT = 2'd2;

  // request rounding granule, a power of two
  localparam int ALIGN_BYTES = 8;

  typedef struct packed {
    logic        mode;
    logic [15:0] req_size;
    logic [19:0] free_addr;
  } bfa_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] user_addr;
    logic [8:0]  blocks_total;
    logic [8:0]  blocks_free;
  } bfa_rsp_t;

endpackage

// ----- src/best_fit_block_allocator_unit.sv -----
// Best-fit block allocator with split on allocate and coalesce on free.
// One item is handled at a time and in_ready is low while it is worked on; a finished
// result waits in the output register, so the next item can start while it waits.
// Every pass walks the block table through one read port and one write port, one entry
// a cycle. An allocate scans all block_count entries, then a split moves the entries
// above the chosen block up one place; a free scans until the block is found, checks
// both neighbours and moves the entries above it down by the number of merges.
// Entry 0 reads as the whole free pool until it is first written, so no clearing pass
// runs after reset. The alignment granule must be a power of two.
module best_fit_block_allocator_unit import bfa_pkg::*; #(
  parameter int POOL_BYTES  = 1048576,
  parameter int MAX_BLOCKS  = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bfa_req_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bfa_rsp_t  out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int IW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = 25;
  localparam int SW = 26;
  localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);
  localparam logic [16:0] ALIGN_MASK = 17'(ALIGN_BYTES - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_PICK  = 4'd3;
  localparam logic [3:0] S_SHUP  = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_NXT   = 4'd6;
  localparam logic [3:0] S_PRV   = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_SDN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [SW-1:0] size;
    logic          free;
  } ent_t;

  ent_t mem [MAX_BLOCKS];
  ent_t rdata;
  ent_t rd_ent;
  logic [IW-1:0] raddr;
  logic [IW-1:0] raddr_q;
  logic          we;
  logic [IW-1:0] waddr;
  ent_t          wdata;

  logic [3:0]    state;
  logic [CW-1:0] block_count, free_count;
  logic [6:0]    header_bytes;
  logic [16:0]   max_block_bytes;
  logic [12:0]   min_split_payload;
  logic          mode;
  logic [SW-1:0] need;
  logic [AW-1:0] target;
  logic [CW-1:0] ptr;
  logic          found;
  logic [IW-1:0] best, idx, widx;
  logic [SW-1:0] best_delta;
  ent_t          best_ent, wbuf;
  logic          merge_next;
  logic [1:0]    rm;
  logic [2:0]    status;
  logic [19:0]   user_addr;
  logic          reset_done;

  logic [7:0]    two_h;
  logic [16:0]   req_al;
  logic [SW-1:0] delta;
  logic [CW-1:0] ptr_p1;
  logic          split_ok;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // table memory, entry 0 reads as the full pool until first written
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
    raddr_q <= raddr;
  end

  assign two_h  = {header_bytes, 1'b0};
  assign req_al = (17'(in_data.req_size) + ALIGN_MASK) & ~ALIGN_MASK;
  assign ptr_p1 = ptr + CW'(1);
  assign rd_ent = (!reset_done && raddr_q == '0) ?
                  ent_t'{start: '0, size: SW'(POOL_BYTES), free: 1'b1} : rdata;
  assign delta  = rd_ent.size - need;
  assign split_ok = (best_delta >= SW'(min_split_payload) + SW'(two_h)) &&
                    (block_count < MAXB);

  always_comb begin
    raddr = ptr[IW-1:0];
    we = 1'b0;
    waddr = ptr[IW-1:0];
    wdata = rd_ent;
    case (state)
      S_PICK: raddr = IW'(block_count - CW'(1));
      S_SHUP: begin
        // move entry ptr-1 up to ptr, fetch ptr-2 for the next move
        raddr = IW'(ptr - CW'(2));
        we = 1'b1;
        waddr = ptr[IW-1:0];
        wdata = rd_ent;
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = IW'(CW'(best) + CW'(1));
        wdata = ent_t'{start: best_ent.start + AW'(need), size: best_delta, free: 1'b1};
      end
      S_NXT: raddr = IW'(CW'(idx) - CW'(1));
      S_WB: begin
        raddr = IW'(ptr + CW'(rm));
        we = 1'b1;
        waddr = widx;
        wdata = wbuf;
      end
      S_SDN: begin
        // move entry ptr+rm down to ptr
        raddr = IW'(ptr + CW'(rm) + CW'(1));
        we = 1'b1;
        waddr = ptr[IW-1:0];
        wdata = rd_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      block_count <= CW'(1);
      free_count <= CW'(1);
      header_bytes <= 7'd32;
      max_block_bytes <= 17'd4096;
      min_split_payload <= 13'd32;
      reset_done <= 1'b0;
    end else begin
      if (we && waddr == '0) reset_done <= 1'b1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEADER:    header_bytes <= cfg_data[6:0];
          REG_MAX_BLOCK: max_block_bytes <= cfg_data;
          REG_MIN_SPLIT: min_split_payload <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          mode <= in_data.mode;
          ptr <= '0;
          found <= 1'b0;
          user_addr <= '0;
          status <= ST_OK;
          need <= SW'(req_al) + SW'(two_h);
          target <= AW'(in_data.free_addr) - AW'(header_bytes);
          if (!in_data.mode) begin
            if (in_data.req_size == '0 || max_block_bytes < 17'(two_h) ||
                17'(in_data.req_size) > max_block_bytes - 17'(two_h)) begin
              status <= ST_BAD_SIZE;
              state <= S_DONE;
            end else state <= S_RD;
          end else if (in_data.free_addr < 20'(header_bytes)) begin
            status <= ST_BAD_ADDR;
            state <= S_DONE;
          end else state <= S_RD;
        end
        S_RD: begin
          ptr <= ptr_p1;
          state <= S_SCAN;
        end
        S_SCAN: begin
          // rd_ent holds entry ptr-1
          if (!mode) begin
            if (rd_ent.free && rd_ent.size >= need && (!found || delta < best_delta)) begin
              found <= 1'b1;
              best_delta <= delta;
              best <= IW'(ptr - CW'(1));
              best_ent <= rd_ent;
            end
            if (ptr >= block_count) state <= S_PICK;
            else ptr <= ptr_p1;
          end else begin
            if (rd_ent.start == target) begin
              idx <= IW'(ptr - CW'(1));
              if (rd_ent.free) begin
                status <= ST_DOUBLE;
                state <= S_DONE;
              end else begin
                best_ent <= ent_t'{start: rd_ent.start, size: rd_ent.size, free: 1'b1};
                state <= S_NXT;
              end
            end else if (ptr >= block_count) begin
              status <= ST_BAD_ADDR;
              state <= S_DONE;
            end else ptr <= ptr_p1;
          end
        end
        S_PICK: begin
          if (!found) begin
            status <= ST_NO_FIT;
            state <= S_DONE;
          end else begin
            user_addr <= 20'(best_ent.start + AW'(header_bytes));
            widx <= best;
            rm <= 2'd0;
            ptr <= block_count;
            if (split_ok) begin
              wbuf <= ent_t'{start: best_ent.start, size: need, free: 1'b0};
              block_count <= block_count + CW'(1);
              if (block_count == CW'(best) + CW'(1)) state <= S_SPLIT;
              else state <= S_SHUP;
            end else begin
              wbuf <= ent_t'{start: best_ent.start, size: best_ent.size, free: 1'b0};
              free_count <= free_count - CW'(1);
              state <= S_WB;
            end
          end
        end
        S_SHUP: begin
          if (ptr == CW'(best) + CW'(2)) state <= S_SPLIT;
          else ptr <= ptr - CW'(1);
        end
        S_SPLIT: state <= S_WB;
        S_NXT: begin
          // rd_ent holds entry idx+1
          if (CW'(idx) + CW'(1) < block_count && rd_ent.free) begin
            best_ent.size <= best_ent.size + rd_ent.size;
            merge_next <= 1'b1;
          end else begin
            merge_next <= 1'b0;
            free_count <= free_count + CW'(1);
          end
          state <= S_PRV;
        end
        S_PRV: begin
          // rd_ent holds entry idx-1
          if (idx != '0 && rd_ent.free) begin
            widx <= idx - IW'(1);
            wbuf <= ent_t'{start: rd_ent.start, size: rd_ent.size + best_ent.size,
                           free: 1'b1};
            ptr <= CW'(idx);
            rm <= merge_next ? 2'd2 : 2'd1;
            block_count <= block_count - (merge_next ? CW'(2) : CW'(1));
            free_count <= free_count - CW'(1);
          end else begin
            widx <= idx;
            wbuf <= best_ent;
            ptr <= CW'(idx) + CW'(1);
            rm <= merge_next ? 2'd1 : 2'd0;
            block_count <= block_count - (merge_next ? CW'(1) : CW'(0));
          end
          state <= S_WB;
        end
        S_WB: begin
          if (rm == 2'd0 || ptr >= block_count) state <= S_DONE;
          else state <= S_SDN;
        end
        S_SDN: begin
          if (ptr + CW'(1) >= block_count) state <= S_DONE;
          else ptr <= ptr_p1;
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_data <= bfa_rsp_t'{status: status,
                                 user_addr: (status == ST_OK) ? user_addr : 20'd0,
                                 blocks_total: 9'(block_count),
                                 blocks_free: 9'(free_count)};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) block_count != '0)
    else $error("block count reached zero");
  assert property (@(posedge clk) disable iff (rst) free_count <= block_count)
    else $error("more free blocks than blocks");
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("ready while busy");

endmodule

// ----- dv/best_fit_block_allocator_unit_tb.sv -----
// testbench for the best-fit block allocator: directed and random requests against a predictor
module best_fit_block_allocator_unit_tb import bfa_pkg::*; ();

  localparam int POOL = 1048576;
  localparam int NBLK = 256;
  localparam int ALIGN = ALIGN_BYTES;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bfa_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bfa_rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_HEADER;
  logic [16:0] cfg_data = '0;

  best_fit_block_allocator_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // allocator state as the testbench sees it
  int unsigned blk_start [NBLK];
  int unsigned blk_size [NBLK];
  bit blk_free [NBLK];
  int unsigned blk_count;
  int unsigned free_total;
  int unsigned hdr_bytes;
  int unsigned max_bytes;
  int unsigned split_min;

  bfa_rsp_t pending_rsp [$];
  int errors = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  function automatic void remove_block(int unsigned idx);
    for (int unsigned k = idx; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k + 1];
      blk_size[k] = blk_size[k + 1];
      blk_free[k] = blk_free[k + 1];
    end
    blk_count--;
  endfunction

  function automatic bfa_rsp_t allocator_step(bfa_req_t r);
    bfa_rsp_t rsp;
    int unsigned two_h, need, best, delta, best_delta, st;
    bit found;
    rsp = '0;
    st = ST_OK;
    two_h = 2 * hdr_bytes;
    best = 0;
    best_delta = 0;
    found = 1'b0;
    if (r.mode == 1'b0) begin
      if (r.req_size == 0 || max_bytes < two_h || r.req_size > max_bytes - two_h) begin
        st = ST_BAD_SIZE;
      end else begin
        need = ((r.req_size + ALIGN - 1) / ALIGN) * ALIGN + two_h;
        for (int unsigned i = 0; i < blk_count; i++) begin
          if (blk_free[i] && blk_size[i] >= need) begin
            delta = blk_size[i] - need;
            if (!found || delta < best_delta) begin
              found = 1'b1;
              best_delta = delta;
              best = i;
            end
          end
        end
        if (!found) begin
          st = ST_NO_FIT;
        end else begin
          if (best_delta >= split_min + two_h && blk_count < NBLK) begin
            for (int unsigned k = blk_count; k > best + 1; k--) begin
              blk_start[k] = blk_start[k - 1];
              blk_size[k] = blk_size[k - 1];
              blk_free[k] = blk_free[k - 1];
            end
            blk_start[best + 1] = blk_start[best] + need;
            blk_size[best + 1] = best_delta;
            blk_free[best + 1] = 1'b1;
            blk_size[best] = need;
            blk_count++;
            free_total++;
          end
          blk_free[best] = 1'b0;
          if (free_total > 0) free_total--;
          rsp.user_addr = 20'(blk_start[best] + hdr_bytes);
        end
      end
    end else begin
      if (r.free_addr < hdr_bytes) begin
        st = ST_BAD_ADDR;
      end else begin
        for (int unsigned i = 0; i < blk_count; i++) begin
          if (!found && blk_start[i] == r.free_addr - hdr_bytes) begin
            found = 1'b1;
            best = i;
          end
        end
        if (!found) begin
          st = ST_BAD_ADDR;
        end else if (blk_free[best]) begin
          st = ST_DOUBLE;
        end else begin
          blk_free[best] = 1'b1;
          free_total++;
          // merge with the next block first, then the previous one
          if (best + 1 < blk_count && blk_free[best + 1]) begin
            blk_size[best] += blk_size[best + 1];
            remove_block(best + 1);
            free_total--;
          end
          if (best > 0 && blk_free[best - 1]) begin
            blk_size[best - 1] += blk_size[best];
            remove_block(best);
            free_total--;
          end
        end
      end
    end
    rsp.status = 3'(st);
    rsp.blocks_total = 9'(blk_count);
    rsp.blocks_free = 9'(free_total);
    return rsp;
  endfunction

  // caller sits at a rising edge
  task automatic send_request(bfa_req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_rsp.push_back(allocator_step(r));
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 17'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_HEADER: hdr_bytes = value & 32'h7f;
      REG_MAX_BLOCK: max_bytes = value & 32'h1ffff;
      default: split_min = value & 32'h1fff;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int unsigned hdr, int unsigned maxb, int unsigned smin);
    wait_idle();
    write_reg(REG_HEADER, hdr);
    write_reg(REG_MAX_BLOCK, maxb);
    write_reg(REG_MIN_SPLIT, smin);
  endtask

  function automatic bfa_req_t alloc_req(int unsigned size);
    bfa_req_t r;
    r = '0;
    r.mode = 1'b0;
    r.req_size = 16'(size);
    r.free_addr = 20'($urandom);
    return r;
  endfunction

  function automatic bfa_req_t free_req(int unsigned addr);
    bfa_req_t r;
    r = '0;
    r.mode = 1'b1;
    r.req_size = 16'($urandom);
    r.free_addr = 20'(addr);
    return r;
  endfunction

  // user address of a random allocated block, or a random address if none
  function automatic int unsigned pick_used_addr();
    int unsigned used [$];
    for (int unsigned i = 0; i < blk_count; i++)
      if (!blk_free[i]) used.push_back(blk_start[i] + hdr_bytes);
    if (used.size() == 0) return $urandom_range(0, POOL - 1);
    return used[$urandom_range(0, used.size() - 1)];
  endfunction

  function automatic int unsigned pick_free_addr();
    int unsigned i;
    i = $urandom_range(0, blk_count - 1);
    return blk_start[i] + hdr_bytes;
  endfunction

  task automatic free_everything();
    while (free_total != blk_count || blk_count > 1) begin
      if (free_total == blk_count) break;
      send_request(free_req(pick_used_addr()));
    end
  endtask

  task automatic test_size_limits();
    send_request(alloc_req(0));
    send_request(alloc_req(1));
    send_request(alloc_req(max_bytes - 2 * hdr_bytes));
    send_request(alloc_req(max_bytes - 2 * hdr_bytes + 1));
    send_request(alloc_req(65535));
    send_request(alloc_req(13));
  endtask

  task automatic test_free_errors();
    send_request(free_req(0));
    send_request(free_req(hdr_bytes - 1));
    send_request(free_req(20'hfffff));
    send_request(free_req(pick_used_addr() + 8));
    send_request(free_req(pick_free_addr()));
    send_request(free_req(pick_used_addr()));
    free_everything();
  endtask

  task automatic test_no_fit();
    set_config(8, 65536, 0);
    repeat (17) send_request(alloc_req(65520));
    send_request(alloc_req(8));
    free_everything();
  endtask

  task automatic test_table_full();
    set_config(8, 4096, 0);
    repeat (NBLK + 3) send_request(alloc_req(8));
    send_request(free_req(pick_used_addr()));
    send_request(alloc_req(8));
    free_everything();
  endtask

  task automatic test_header_overflow();
    set_config(64, 64, 4096);
    send_request(alloc_req(1));
    send_request(alloc_req(65535));
    send_request(free_req(pick_free_addr()));
  endtask

  task automatic test_backpressure();
    set_config(32, 4096, 32);
    @(posedge clk);
    hold_cycles = 1500;
    repeat (8) send_request(alloc_req($urandom_range(1, 200)));
    free_everything();
  endtask

  task automatic random_phase(int n, int unsigned hdr, int unsigned maxb, int unsigned smin);
    int unsigned sel, lim;
    set_config(hdr, maxb, smin);
    lim = (maxb > 2 * hdr) ? maxb - 2 * hdr : 1;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) send_request(alloc_req($urandom_range(1, (lim < 256) ? lim : 256)));
      else if (sel < 50) send_request(alloc_req($urandom_range(1, lim > 65535 ? 65535 : lim)));
      else if (sel < 53) send_request(alloc_req($urandom_range(0, 65535)));
      else if (sel < 88) send_request(free_req(pick_used_addr()));
      else if (sel < 93) send_request(free_req(pick_free_addr()));
      else if (sel < 97) send_request(free_req($urandom_range(0, POOL - 1)));
      else send_request(free_req($urandom_range(0, hdr + 1)));
    end
  endtask

  task automatic test_random();
    random_phase(70, 32, 4096, 32);
    random_phase(60, 8, 65536, 0);
    random_phase(50, 64, 1024, 4096);
    random_phase(50, $urandom_range(8, 64), $urandom_range(64, 65536),
                 $urandom_range(0, 4096));
    wait_idle();
    idle_on = 1'b0;
    random_phase(40, 16, 2048, 64);
  endtask

  // result side: check each item, then decide next ready
  initial begin
    int stall_left;
    bfa_rsp_t want;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_rsp.size() == 0) begin
          $error("result with no expectation: %p", out_data);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_data.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.user_addr !== want.user_addr) begin
            $error("user_addr expected %0h actual %0h", want.user_addr, out_data.user_addr);
            errors++;
          end
          if (out_data.blocks_total !== want.blocks_total) begin
            $error("blocks_total expected %0d actual %0d", want.blocks_total,
                   out_data.blocks_total);
            errors++;
          end
          if (out_data.blocks_free !== want.blocks_free) begin
            $error("blocks_free expected %0d actual %0d", want.blocks_free,
                   out_data.blocks_free);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        stall_left = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    hdr_bytes = 32;
    max_bytes = 4096;
    split_min = 32;
    blk_start[0] = 0;
    blk_size[0] = POOL;
    blk_free[0] = 1'b1;
    blk_count = 1;
    free_total = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_size_limits();
    test_free_errors();
    test_no_fit();
    test_table_full();
    test_header_overflow();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
src/bfa_pkg.sv
src/best_fit_block_allocator_unit.sv
dv/best_fit_block_allocator_unit_tb.sv
